/* design/lse_pkg.sv */
package lse_pkg;

	localparam int MaxLeds   = 64;
	localparam int MaxColors = 16;
	localparam int LedIdxW   = $clog2(MaxLeds);
	localparam int ColIdxW   = $clog2(MaxColors);
	localparam int DivNumW   = 17;
	localparam int DivDenW   = 11;
	localparam int DivSteps  = DivNumW;
	localparam int DivCntW   = $clog2(DivSteps + 1);

	localparam logic [8:0]  FullLevel = 9'd256;
	localparam logic [15:0] SeedReset = 16'hACE1;
	localparam logic [23:0] White     = 24'hFFFFFF;

	typedef enum logic [1:0] {
		CMD_RENDER = 2'd0,
		CMD_LOAD   = 2'd1,
		CMD_BLANK  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		MODE_SOLID     = 3'd0,
		MODE_CHASE     = 3'd1,
		MODE_TWINKLE   = 3'd2,
		MODE_SEQUENCE  = 3'd3,
		MODE_STRIPES   = 3'd4,
		MODE_COMETS    = 3'd5,
		MODE_FIREWORKS = 3'd6,
		MODE_SOLID_ALT = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		REG_EFFECT_MODE   = 3'd0,
		REG_STRIP_LENGTH  = 3'd1,
		REG_PALETTE_SIZE  = 3'd2,
		REG_GLOBAL_LEVEL  = 3'd3,
		REG_DENSITY       = 3'd4,
		REG_FADE_FACTOR   = 3'd5,
		REG_REVERSE_ORDER = 3'd6,
		REG_RGB_STRIP     = 3'd7
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_FILL,
		ST_ADV,
		ST_ADV_W,
		ST_POS,
		ST_POS_W,
		ST_CHASE,
		ST_BAND,
		ST_FD_RD,
		ST_FD_CHK,
		ST_FD_DIV,
		ST_FD_WR,
		ST_SP_RAND,
		ST_SP_KW,
		ST_SP_CRAND,
		ST_SP_RD,
		ST_SP_CHK,
		ST_SP_CW,
		ST_SP_WR,
		ST_SP_NEXT,
		ST_EM_RD,
		ST_EM_S,
		ST_EM_C,
		ST_EM_OUT
	} state_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [8:0] level;
		logic       rising;
	} pix_t;

	typedef struct packed {
		logic               start;
		logic [DivNumW-1:0] dividend;
		logic [DivDenW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DivNumW-1:0] quot;
		logic [DivDenW-1:0] rem;
	} div_rsp_t;

	// Level of a tail pixel: full level shifted right by floor(num / den), zero past eight.
	function automatic logic [8:0] tail_level(input logic [16:0] num, input logic [14:0] den);
		logic [3:0]  k;
		logic [18:0] lim;
		k = '0;
		for (int j = 1; j <= 9; j++) begin
			lim = 19'(den) * 19'(j);
			if ({2'b00, num} >= lim) k = 4'(j);
		end
		return (k > 4'd8) ? 9'd0 : (FullLevel >> k);
	endfunction

	function automatic logic [15:0] lfsr_next(input logic [15:0] s);
		logic b;
		b = s[0] ^ s[2] ^ s[3] ^ s[5];
		return {b, s[15:1]};
	endfunction

endpackage

/* design/lse_div.sv */
module lse_div (
	input  logic              clk,
	input  logic              arst_n,
	input  lse_pkg::div_req_t req,
	output lse_pkg::div_rsp_t rsp
);
	import lse_pkg::*;

	logic               busy_q;
	logic               done_q;
	logic [DivCntW-1:0] cnt_q;
	logic [DivNumW-1:0] quo_q;
	logic [DivDenW-1:0] rem_q;
	logic [DivDenW-1:0] dvs_q;
	logic [DivDenW:0]   trial;
	logic               ge;

	assign trial = {rem_q, quo_q[DivNumW-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DivCntW'(DivSteps);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DivCntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// One quotient bit per cycle, restoring form.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DivNumW-2:0], ge};
			rem_q <= ge ? DivDenW'(trial - {1'b0, dvs_q}) : DivDenW'(trial);
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

/* design/led_strip_effect_engine.sv */
// Animation engine for an addressable LED strip of up to 64 pixels. A render transaction
// runs one frame of the selected effect over the pixel memory and then sends one output
// transaction per LED in position order, the last flagged by last_pixel; a blank transaction
// sends the same sequence with all color bytes zero, and a load transaction writes one
// palette entry and sends nothing. Rendering needs at least one palette color. Pixel state
// sits in a 64-entry memory with a registered read, and a single serial divider does every
// modulo and the division for a rising pixel. Each LED is read, scaled and registered before
// output and then waits on out_ready. Solid fill writes each LED once; chase, sequence,
// stripes and comets first take a position step on the divider (all but chase with a second
// division), and twinkle and fireworks run a fade pass, dividing for a rising pixel, and then
// place the sparks.
module led_strip_effect_engine (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] command,
	input  logic [3:0] palette_slot,
	input  logic [7:0] load_red,
	input  logic [7:0] load_green,
	input  logic [7:0] load_blue,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [5:0] led_position,
	output logic [7:0] wire_green,
	output logic [7:0] wire_red,
	output logic [7:0] wire_blue,
	output logic       last_pixel,
	input  logic       cfg_write,
	input  logic [2:0] cfg_index,
	input  logic [8:0] cfg_data
);
	import lse_pkg::*;

	// Configuration registers.
	mode_t      mode_q;
	logic [6:0] strip_cfg_q;
	logic [4:0] pal_cfg_q;
	logic [8:0] glev_cfg_q;
	logic [8:0] dens_cfg_q;
	logic [8:0] fade_cfg_q;
	logic       rev_q;
	logic       rgb_q;

	// Frame registers.
	state_t     state_q, state_d;
	logic [6:0] len_q;
	logic [4:0] cc_q;
	logic [8:0] f_q;
	logic [6:0] sparks_q;
	logic [6:0] wb_q;
	logic       chase_q;
	logic       comet_q;
	logic       twinkle_q;
	logic       blank_q;
	logic [10:0] pos_q;
	logic [15:0] seed_q;
	logic [6:0] i_q;
	logic [6:0] m_q;
	logic [ColIdxW-1:0] ci_q;
	logic [ColIdxW-1:0] c_q;
	logic [6:0] cnt_q;
	logic [LedIdxW-1:0] k_q;
	pix_t       pix_q;
	logic [16:0] fraw_q;
	logic [16:0] s_q;
	pix_t       epix_q;
	logic       out_valid_q;

	// Memories.
	logic [23:0] palette_q [MaxColors];
	pix_t        pix_mem [MaxLeds];
	logic [MaxLeds-1:0] vld_q;
	pix_t        rd_q;
	logic        rd_vld_q;
	pix_t        rd_pix;

	logic               mem_we;
	logic [LedIdxW-1:0] mem_waddr;
	logic [LedIdxW-1:0] mem_raddr;
	pix_t               mem_wdata;
	logic [ColIdxW-1:0] pal_addr;
	logic [23:0]        pal_rgb;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// Saturated views of the registers.
	logic [6:0] len_sat;
	logic [4:0] cc_sat;
	logic [8:0] f_sat;
	logic [8:0] dens_sat;
	logic [8:0] glev_sat;
	logic [6:0] sparks_new;
	logic       accept;
	logic       last_i;
	logic [15:0] seed_nx;

	logic [4:0]  chase_d;
	logic [14:0] chase_den;
	logic [14:0] band_den;
	logic [11:0] band_mod;
	logic        m_zero;
	logic [ColIdxW-1:0] ci_use;
	logic [6:0]  m_next_cc;
	logic [6:0]  m_next_wb;
	logic        fd_rise;
	logic [17:0] fade_prod;
	logic [8:0]  fd_level;
	logic [8:0]  lvl;
	logic [LedIdxW-1:0] em_addr;
	logic [17:0] s_prod;
	logic [24:0] r_prod, g_prod, b_prod;

	assign len_sat    = (strip_cfg_q > 7'(MaxLeds)) ? 7'(MaxLeds) : strip_cfg_q;
	assign cc_sat     = (pal_cfg_q > 5'(MaxColors)) ? 5'(MaxColors) : pal_cfg_q;
	assign f_sat      = (fade_cfg_q > FullLevel) ? FullLevel : fade_cfg_q;
	assign dens_sat   = (dens_cfg_q > FullLevel) ? FullLevel : dens_cfg_q;
	assign glev_sat   = (glev_cfg_q > FullLevel) ? FullLevel : glev_cfg_q;
	assign sparks_new = 7'((16'(len_sat) * 16'(dens_sat)) >> 8);
	assign accept     = in_valid && in_ready;
	assign last_i     = (i_q == len_q - 7'd1);
	assign seed_nx    = lfsr_next(seed_q);
	assign pal_rgb    = palette_q[pal_addr];
	assign rd_pix     = rd_vld_q ? rd_q : '0;

	assign chase_d   = (pos_q[4:0] > m_q[4:0]) ? pos_q[4:0] - m_q[4:0] : m_q[4:0] - pos_q[4:0];
	assign chase_den = 15'(15'(cc_q) * 15'(f_q));
	assign band_den  = 15'(16'(wb_q) * 16'(f_q));
	assign band_mod  = 12'(cc_q) * 12'(wb_q);
	assign m_zero    = (m_q == 7'd0);
	assign m_next_cc = (m_q + 7'd1 == 7'(cc_q)) ? 7'd0 : m_q + 7'd1;
	assign m_next_wb = (m_q + 7'd1 == wb_q) ? 7'd0 : m_q + 7'd1;
	assign ci_use    = (m_zero && i_q != 7'd0) ?
		((5'(ci_q) + 5'd1 == cc_q) ? '0 : ci_q + 1'b1) : ci_q;

	assign fd_rise   = rd_pix.rising && !(twinkle_q && rd_pix.level == FullLevel);
	assign fade_prod = 18'(rd_pix.level) * 18'(f_q);
	assign fd_level  = (fraw_q > 17'(FullLevel)) ? FullLevel : fraw_q[8:0];

	assign em_addr = rev_q ? LedIdxW'(len_q - 7'd1 - i_q) : i_q[LedIdxW-1:0];
	assign s_prod  = 18'(rd_pix.level) * 18'(glev_sat);
	assign r_prod  = 25'(epix_q.red) * 25'(s_q);
	assign g_prod  = 25'(epix_q.green) * 25'(s_q);
	assign b_prod  = 25'(epix_q.blue) * 25'(s_q);

	lse_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = i_q[LedIdxW-1:0];
		mem_raddr = i_q[LedIdxW-1:0];
		mem_wdata = '0;
		pal_addr  = '0;
		div_req   = '0;
		lvl       = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (cmd_t'(command))
						CMD_BLANK: if (len_sat != 7'd0) state_d = ST_EM_RD;
						CMD_RENDER: begin
							if (len_sat != 7'd0 && cc_sat != 5'd0) begin
								unique case (mode_q) inside
									MODE_CHASE, MODE_SEQUENCE, MODE_STRIPES, MODE_COMETS:
										state_d = ST_ADV;
									MODE_TWINKLE, MODE_FIREWORKS: state_d = ST_FD_RD;
									default: state_d = ST_FILL;
								endcase
							end
						end
						default: ;
					endcase
				end
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_wdata = '{red: pal_rgb[23:16], green: pal_rgb[15:8], blue: pal_rgb[7:0],
					level: FullLevel, rising: 1'b0};
				if (last_i) state_d = ST_EM_RD;
			end
			ST_ADV: begin
				div_req.start    = 1'b1;
				div_req.dividend = DivNumW'(11'(pos_q + 11'd1));
				div_req.divisor  = chase_q ? DivDenW'(cc_q) : DivDenW'(band_mod);
				state_d          = ST_ADV_W;
			end
			ST_ADV_W: if (div_rsp.done) state_d = chase_q ? ST_CHASE : ST_POS;
			ST_POS: begin
				div_req.start    = 1'b1;
				div_req.dividend = DivNumW'(pos_q);
				div_req.divisor  = DivDenW'(wb_q);
				state_d          = ST_POS_W;
			end
			ST_POS_W: if (div_rsp.done) state_d = ST_BAND;
			ST_CHASE: begin
				pal_addr = m_q[ColIdxW-1:0];
				if (chase_den != 15'd0) lvl = tail_level(17'({chase_d, 10'b0}), chase_den);
				else lvl = (chase_d == 5'd0) ? FullLevel : 9'd0;
				mem_we    = 1'b1;
				mem_wdata = '{red: pal_rgb[23:16], green: pal_rgb[15:8], blue: pal_rgb[7:0],
					level: lvl, rising: 1'b0};
				if (last_i) state_d = ST_EM_RD;
			end
			ST_BAND: begin
				pal_addr = ci_use;
				mem_we   = 1'b1;
				if (comet_q && m_zero) begin
					mem_wdata = '{red: White[23:16], green: White[15:8], blue: White[7:0],
						level: FullLevel, rising: 1'b0};
				end else begin
					if (!comet_q) lvl = FullLevel;
					else if (band_den != 15'd0)
						lvl = tail_level(17'({m_q[5:0], 10'b0}), band_den);
					mem_wdata = '{red: pal_rgb[23:16], green: pal_rgb[15:8], blue: pal_rgb[7:0],
						level: lvl, rising: 1'b0};
				end
				if (last_i) state_d = ST_EM_RD;
			end
			ST_FD_RD: state_d = ST_FD_CHK;
			ST_FD_CHK: begin
				if (fd_rise && f_q != 9'd0) begin
					div_req.start    = 1'b1;
					div_req.dividend = DivNumW'({rd_pix.level, 8'b0});
					div_req.divisor  = DivDenW'(f_q);
					state_d          = ST_FD_DIV;
				end else begin
					state_d = ST_FD_WR;
				end
			end
			ST_FD_DIV: if (div_rsp.done) state_d = ST_FD_WR;
			ST_FD_WR: begin
				// A level that falls below a quarter of the fade factor goes dark.
				lvl       = ((11'(fd_level) << 2) < 11'(f_q)) ? 9'd0 : fd_level;
				mem_we    = 1'b1;
				mem_wdata = pix_q;
				mem_wdata.level = lvl;
				if (last_i) state_d = (sparks_q == 7'd0) ? ST_EM_RD : ST_SP_RAND;
				else state_d = ST_FD_RD;
			end
			ST_SP_RAND: begin
				div_req.start    = 1'b1;
				div_req.dividend = DivNumW'(seed_nx);
				div_req.divisor  = DivDenW'(len_q);
				state_d          = ST_SP_KW;
			end
			ST_SP_KW: if (div_rsp.done) state_d = twinkle_q ? ST_SP_RD : ST_SP_CRAND;
			ST_SP_CRAND: begin
				div_req.start    = 1'b1;
				div_req.dividend = DivNumW'(seed_nx);
				div_req.divisor  = DivDenW'(cc_q);
				state_d          = ST_SP_CW;
			end
			ST_SP_RD: begin
				mem_raddr = k_q;
				state_d   = ST_SP_CHK;
			end
			ST_SP_CHK: begin
				if (rd_pix.level == 9'd0) begin
					div_req.start    = 1'b1;
					div_req.dividend = DivNumW'(k_q);
					div_req.divisor  = DivDenW'(cc_q);
					state_d          = ST_SP_CW;
				end else begin
					state_d = ST_SP_NEXT;
				end
			end
			ST_SP_CW: if (div_rsp.done) state_d = ST_SP_WR;
			ST_SP_WR: begin
				pal_addr  = c_q;
				mem_we    = 1'b1;
				mem_waddr = k_q;
				mem_wdata = '{red: pal_rgb[23:16], green: pal_rgb[15:8], blue: pal_rgb[7:0],
					level: twinkle_q ? 9'(f_q >> 2) : FullLevel, rising: twinkle_q};
				state_d   = ST_SP_NEXT;
			end
			ST_SP_NEXT: state_d = (cnt_q == 7'd1) ? ST_EM_RD : ST_SP_RAND;
			ST_EM_RD: begin
				mem_raddr = em_addr;
				state_d   = ST_EM_S;
			end
			ST_EM_S: state_d = ST_EM_C;
			ST_EM_C: state_d = ST_EM_OUT;
			ST_EM_OUT: if (out_ready) state_d = last_i ? ST_IDLE : ST_EM_RD;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration, persistent animation state and handshake flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_SOLID;
			strip_cfg_q <= 7'(MaxLeds);
			pal_cfg_q   <= '0;
			glev_cfg_q  <= FullLevel;
			dens_cfg_q  <= 9'd64;
			fade_cfg_q  <= 9'd128;
			rev_q       <= 1'b0;
			rgb_q       <= 1'b0;
			pos_q       <= '1;
			seed_q      <= SeedReset;
			vld_q       <= '0;
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (reg_idx_t'(cfg_index))
					REG_EFFECT_MODE:   mode_q      <= mode_t'(cfg_data[2:0]);
					REG_STRIP_LENGTH:  strip_cfg_q <= cfg_data[6:0];
					REG_PALETTE_SIZE:  pal_cfg_q   <= cfg_data[4:0];
					REG_GLOBAL_LEVEL:  glev_cfg_q  <= cfg_data;
					REG_DENSITY:       dens_cfg_q  <= cfg_data;
					REG_FADE_FACTOR:   fade_cfg_q  <= cfg_data;
					REG_REVERSE_ORDER: rev_q       <= cfg_data[0];
					REG_RGB_STRIP:     rgb_q       <= cfg_data[0];
					default: ;
				endcase
			end
			if (state_q == ST_ADV_W && div_rsp.done) pos_q <= div_rsp.rem;
			if (state_q == ST_SP_RAND || state_q == ST_SP_CRAND) seed_q <= seed_nx;
			if (mem_we) vld_q[mem_waddr] <= 1'b1;
			rd_vld_q <= vld_q[mem_raddr];
			if (state_q == ST_EM_C) out_valid_q <= 1'b1;
			else if (state_q == ST_EM_OUT && out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) pix_mem[mem_waddr] <= mem_wdata;
		rd_q <= pix_mem[mem_raddr];
		if (accept && cmd_t'(command) == CMD_LOAD) begin
			palette_q[palette_slot] <= {load_red, load_green, load_blue};
		end
	end

	// Frame datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				len_q     <= len_sat;
				cc_q      <= cc_sat;
				f_q       <= f_sat;
				sparks_q  <= sparks_new;
				cnt_q     <= sparks_new;
				wb_q      <= (mode_q == MODE_SEQUENCE || sparks_new == 7'd0) ? 7'd1 : sparks_new;
				chase_q   <= (mode_q == MODE_CHASE);
				comet_q   <= (mode_q == MODE_COMETS);
				twinkle_q <= (mode_q == MODE_TWINKLE);
				blank_q   <= (cmd_t'(command) == CMD_BLANK);
				i_q       <= '0;
				m_q       <= '0;
			end
			ST_FILL: i_q <= last_i ? 7'd0 : i_q + 7'd1;
			ST_POS_W: begin
				if (div_rsp.done) begin
					ci_q <= div_rsp.quot[ColIdxW-1:0];
					m_q  <= div_rsp.rem[6:0];
				end
			end
			ST_CHASE: begin
				i_q <= last_i ? 7'd0 : i_q + 7'd1;
				m_q <= m_next_cc;
			end
			ST_BAND: begin
				i_q  <= last_i ? 7'd0 : i_q + 7'd1;
				m_q  <= m_next_wb;
				ci_q <= ci_use;
			end
			ST_FD_CHK: begin
				pix_q  <= '{red: rd_pix.red, green: rd_pix.green, blue: rd_pix.blue,
					level: rd_pix.level, rising: fd_rise};
				fraw_q <= fd_rise ? 17'(FullLevel) : 17'(fade_prod >> 8);
			end
			ST_FD_DIV: if (div_rsp.done) fraw_q <= div_rsp.quot;
			ST_FD_WR: i_q <= last_i ? 7'd0 : i_q + 7'd1;
			ST_SP_KW: if (div_rsp.done) k_q <= div_rsp.rem[LedIdxW-1:0];
			ST_SP_CW: if (div_rsp.done) c_q <= div_rsp.rem[ColIdxW-1:0];
			ST_SP_NEXT: cnt_q <= cnt_q - 7'd1;
			ST_EM_S: begin
				s_q    <= blank_q ? 17'd0 : 17'(s_prod);
				epix_q <= rd_pix;
			end
			ST_EM_C: begin
				led_position <= i_q[LedIdxW-1:0];
				last_pixel   <= last_i;
				wire_green   <= rgb_q ? r_prod[23:16] : g_prod[23:16];
				wire_red     <= rgb_q ? g_prod[23:16] : r_prod[23:16];
				wire_blue    <= b_prod[23:16];
			end
			ST_EM_OUT: if (out_ready) i_q <= last_i ? 7'd0 : i_q + 7'd1;
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
